[rtl/core/sha1_pkg.sv]
// ----------------------------------------------------------------------------
// sha1 package
// shared types and constants of the sha-1 stream hasher
// ----------------------------------------------------------------------------
`default_nettype none
package sha1_pkg;
    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hefcdab89;
    localparam logic [31:0] H2 = 32'h98badcfe;
    localparam logic [31:0] H3 = 32'h10325476;
    localparam logic [31:0] H4 = 32'hc3d2e1f0;
    localparam logic [31:0] K0 = 32'h5a827999;
    localparam logic [31:0] K1 = 32'h6ed9eba1;
    localparam logic [31:0] K2 = 32'h8f1bbcdc;
    localparam logic [31:0] K3 = 32'hca62c1d6;
    localparam logic [7:0]  PAD_BYTE = 8'h80;

    // one queued command from front to back
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } sha1_cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_PAD,
        ST_LEN,
        ST_OUT
    } sha1_state_t;

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
        rotl = (x << n) | (x >> (6'd32 - {1'b0, n}));
    endfunction
endpackage
`default_nettype wire

[rtl/core/sha1_front.sv]
// ----------------------------------------------------------------------------
// sha1 front
// accepts input beats and holds them in a short queue for the back end
// ----------------------------------------------------------------------------
`default_nettype none
module sha1_front (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_ready,
    input  wire sha1_pkg::sha1_cmd_t in_cmd,
    output logic                q_valid,
    input  wire                 q_ready,
    output sha1_pkg::sha1_cmd_t q_cmd
);
    sha1_pkg::sha1_cmd_t mem [4];
    logic [1:0] wptr_reg, rptr_reg;
    logic [2:0] count_reg;
    logic push, pop;

    assign in_ready = (count_reg != 3'd4);
    assign q_valid  = (count_reg != 3'd0);
    assign push = in_valid && in_ready;
    assign pop  = q_valid && q_ready;
    assign q_cmd = mem[rptr_reg];

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wptr_reg] <= in_cmd;
        end
    end

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push) wptr_reg <= wptr_reg + 2'd1;
            if (pop)  rptr_reg <= rptr_reg + 2'd1;
            count_reg <= count_reg + {2'b0, push} - {2'b0, pop};
        end
    end
endmodule
`default_nettype wire

[rtl/core/sha1_back.sv]
// ----------------------------------------------------------------------------
// sha1 back
// block buffer, padding, 80-round compression and digest output
// ----------------------------------------------------------------------------
`default_nettype none
module sha1_back (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 q_valid,
    output logic                q_ready,
    input  wire sha1_pkg::sha1_cmd_t q_cmd,
    output logic                out_valid,
    input  wire                 out_ready,
    output logic [31:0]         digest_word,
    output logic [2:0]          word_index,
    output logic                last_word
);
    sha1_pkg::sha1_state_t state_reg, state_next;
    logic [31:0] w_reg [16];
    logic [31:0] h_reg [5];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [5:0]  fill_reg;
    logic [63:0] total_reg;
    logic [6:0]  round_reg;
    logic        after_pad_reg;   // a length block still follows
    logic        finish_reg;      // message has ended; digest follows its last block
    logic        data_block_reg;  // rounds run on a full data block
    logic [2:0]  idx_reg;

    logic [31:0] wt, wnew, f, k, tmp;
    logic [3:0]  wsel;
    logic        take, byte_in, block_full;
    logic        round_last;
    logic [63:0] bits;

    assign bits = {total_reg[60:0], 3'b000};
    assign take = (state_reg == sha1_pkg::ST_IDLE) && q_valid;
    assign byte_in = take && q_cmd.byte_present;
    assign block_full = byte_in && (fill_reg == 6'd63);
    assign round_last = (round_reg == 7'd79);

    // message schedule and round function
    always_comb
    begin
        wsel = round_reg[3:0];
        wnew = sha1_pkg::rotl(w_reg[4'(wsel + 4'd13)] ^ w_reg[4'(wsel + 4'd8)]
                            ^ w_reg[4'(wsel + 4'd2)] ^ w_reg[wsel], 5'd1);
        wt = (round_reg < 7'd16) ? w_reg[wsel] : wnew;
        if (round_reg < 7'd20)
        begin
            f = (b_reg & c_reg) | (~b_reg & d_reg);
            k = sha1_pkg::K0;
        end
        else if (round_reg < 7'd40)
        begin
            f = b_reg ^ c_reg ^ d_reg;
            k = sha1_pkg::K1;
        end
        else if (round_reg < 7'd60)
        begin
            f = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k = sha1_pkg::K2;
        end
        else
        begin
            f = b_reg ^ c_reg ^ d_reg;
            k = sha1_pkg::K3;
        end
        tmp = sha1_pkg::rotl(a_reg, 5'd5) + f + e_reg + wt + k;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sha1_pkg::ST_IDLE:
            begin
                if (block_full) state_next = sha1_pkg::ST_ROUND;
                else if (take && q_cmd.end_of_message) state_next = sha1_pkg::ST_PAD;
            end
            sha1_pkg::ST_PAD:   state_next = sha1_pkg::ST_ROUND;
            sha1_pkg::ST_LEN:   state_next = sha1_pkg::ST_ROUND;
            sha1_pkg::ST_ROUND:
            begin
                if (round_last)
                begin
                    if (after_pad_reg)                       state_next = sha1_pkg::ST_LEN;
                    else if (finish_reg && data_block_reg)   state_next = sha1_pkg::ST_PAD;
                    else if (finish_reg)                     state_next = sha1_pkg::ST_OUT;
                    else                                     state_next = sha1_pkg::ST_IDLE;
                end
            end
            sha1_pkg::ST_OUT:
            begin
                if (out_ready && idx_reg == 3'd4) state_next = sha1_pkg::ST_IDLE;
            end
            default: state_next = sha1_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        q_ready = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            sha1_pkg::ST_IDLE: q_ready = 1'b1;
            sha1_pkg::ST_OUT:  out_valid = 1'b1;
            default: ;
        endcase
    end
    assign digest_word = h_reg[idx_reg];
    assign word_index  = idx_reg;
    assign last_word   = (idx_reg == 3'd4);

    // block words, written a byte at a time, padded, and overwritten in place during rounds
    always_ff @(posedge clk)
    begin
        if (byte_in)
        begin
            case (fill_reg[1:0])
                2'd0: w_reg[fill_reg[5:2]][31:24] <= q_cmd.data_byte;
                2'd1: w_reg[fill_reg[5:2]][23:16] <= q_cmd.data_byte;
                2'd2: w_reg[fill_reg[5:2]][15:8]  <= q_cmd.data_byte;
                default: w_reg[fill_reg[5:2]][7:0] <= q_cmd.data_byte;
            endcase
        end
        else if (state_reg == sha1_pkg::ST_PAD)
        begin
            // pad byte after the data, zeros beyond, length if it fits
            for (int j = 0; j < 16; j++)
            begin
                if (j < 14 || fill_reg >= 6'd56)
                begin
                    for (int bb = 0; bb < 4; bb++)
                    begin
                        if (6'(j * 4 + bb) == fill_reg)
                            w_reg[j][31 - bb * 8 -: 8] <= sha1_pkg::PAD_BYTE;
                        else if (6'(j * 4 + bb) > fill_reg)
                            w_reg[j][31 - bb * 8 -: 8] <= 8'h00;
                    end
                end
            end
            if (fill_reg < 6'd56)
            begin
                w_reg[14] <= bits[63:32];
                w_reg[15] <= bits[31:0];
            end
        end
        else if (state_reg == sha1_pkg::ST_LEN)
        begin
            for (int j = 0; j < 14; j++) w_reg[j] <= '0;
            w_reg[14] <= bits[63:32];
            w_reg[15] <= bits[31:0];
        end
        else if (state_reg == sha1_pkg::ST_ROUND && round_reg >= 7'd16)
        begin
            w_reg[wsel] <= wnew;
        end
    end

    // working variables
    always_ff @(posedge clk)
    begin
        if (state_reg == sha1_pkg::ST_ROUND)
        begin
            a_reg <= tmp;
            b_reg <= a_reg;
            c_reg <= sha1_pkg::rotl(b_reg, 5'd30);
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
        else
        begin
            a_reg <= h_reg[0];
            b_reg <= h_reg[1];
            c_reg <= h_reg[2];
            d_reg <= h_reg[3];
            e_reg <= h_reg[4];
        end
    end

    // control and chaining value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sha1_pkg::ST_IDLE;
            h_reg[0] <= sha1_pkg::H0;
            h_reg[1] <= sha1_pkg::H1;
            h_reg[2] <= sha1_pkg::H2;
            h_reg[3] <= sha1_pkg::H3;
            h_reg[4] <= sha1_pkg::H4;
            fill_reg <= '0;
            total_reg <= '0;
            round_reg <= '0;
            after_pad_reg <= 1'b0;
            finish_reg <= 1'b0;
            data_block_reg <= 1'b0;
            idx_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (byte_in)
            begin
                fill_reg <= fill_reg + 6'd1;
                total_reg <= total_reg + 64'd1;
            end
            if (take)
            begin
                finish_reg <= q_cmd.end_of_message;
            end
            // mark a full data block; if its beat also ends the message, an empty block is padded next
            if (block_full)
            begin
                data_block_reg <= 1'b1;
            end
            if (state_reg == sha1_pkg::ST_PAD)
            begin
                after_pad_reg <= (fill_reg >= 6'd56);
                data_block_reg <= 1'b0;
            end
            if (state_reg == sha1_pkg::ST_LEN)
            begin
                after_pad_reg <= 1'b0;
            end
            if (state_reg == sha1_pkg::ST_ROUND)
            begin
                round_reg <= round_last ? 7'd0 : round_reg + 7'd1;
                if (round_last)
                begin
                    h_reg[0] <= h_reg[0] + tmp;
                    h_reg[1] <= h_reg[1] + a_reg;
                    h_reg[2] <= h_reg[2] + sha1_pkg::rotl(b_reg, 5'd30);
                    h_reg[3] <= h_reg[3] + c_reg;
                    h_reg[4] <= h_reg[4] + d_reg;
                end
            end
            if (state_reg == sha1_pkg::ST_OUT && out_ready)
            begin
                idx_reg <= (idx_reg == 3'd4) ? 3'd0 : idx_reg + 3'd1;
                if (idx_reg == 3'd4)
                begin
                    h_reg[0] <= sha1_pkg::H0;
                    h_reg[1] <= sha1_pkg::H1;
                    h_reg[2] <= sha1_pkg::H2;
                    h_reg[3] <= sha1_pkg::H3;
                    h_reg[4] <= sha1_pkg::H4;
                    fill_reg <= '0;
                    total_reg <= '0;
                    finish_reg <= 1'b0;
                end
            end
        end
    end
endmodule
`default_nettype wire

[rtl/core/sha1_stream_hasher.sv]
// ----------------------------------------------------------------------------
// sha1 stream hasher
// sha-1 over a byte stream, five digest words per message
// ----------------------------------------------------------------------------
//  channel  dir  tdata                      tuser / tlast
//  s_axis   in   [7:0] data_byte            tuser [0] byte_present, tlast end_of_message
//  m_axis   out  [31:0] digest_word         tuser [2:0] word_index, tlast last_word
//
//  the back end takes beats only while idle; a full block then runs the rounds,
//  and end of message adds a padding block, a length block if the length does
//  not fit, and five output beats; the single shared round unit sets the rate
//  a four-entry queue keeps accepting beats, until full, while the rounds run
//  rst_n clears control state and loads the initial hash words
// ----------------------------------------------------------------------------
`default_nettype none
module sha1_stream_hasher (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire         s_axis_tuser,   // [0] byte_present
    input  wire         s_axis_tlast,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]  m_axis_tuser,   // [2:0] word_index
    output logic        m_axis_tlast
);
    sha1_pkg::sha1_cmd_t in_cmd, q_cmd;
    logic q_valid, q_ready;

    // pack the incoming beat
    always_comb
    begin
        in_cmd.data_byte = s_axis_tdata;
        in_cmd.byte_present = s_axis_tuser;
        in_cmd.end_of_message = s_axis_tlast;
    end

    sha1_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_cmd(in_cmd),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
    );

    sha1_back u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .digest_word(m_axis_tdata), .word_index(m_axis_tuser),
        .last_word(m_axis_tlast)
    );
endmodule
`default_nettype wire
